// ===== hdl/ilff_pkg.sv =====
`default_nettype none

package ilff_pkg;

    // Heap geometry
    localparam int HEAP_WORDS     = 4096;
    localparam int ALIGN_BYTES    = 8;     // power of two, multiple of 8
    localparam int HEADER_BYTES   = 8;
    localparam int HDR_SHIFT      = $clog2(HEADER_BYTES);
    localparam int HW_AW          = $clog2(HEAP_WORDS);
    // A walk step adds at most 2^(HDR_W-HDR_SHIFT) words to a position below HEAP_WORDS
    localparam int HDR_W          = 16;
    localparam int POS_W          = $clog2(HEAP_WORDS + (1 << (HDR_W - HDR_SHIFT)));
    localparam int HEAP_MAX_BYTES = HEAP_WORDS * HEADER_BYTES;
    localparam int HEAP_MIN_BYTES = 2 * HEADER_BYTES;

    // Field widths
    localparam int ADDR_W     = 48;
    localparam int REQ_W      = 32;
    localparam int MAXREQ_W   = 31;
    localparam int HBYTES_W   = 16;
    localparam int BC_W       = 12;
    localparam int MODE_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;

    // Modes
    localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;

    // Result status
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FAIL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_REQUEST = 2'd2;

    // Register reset values
    localparam logic [ADDR_W-1:0]   RST_HEAP_BASE   = '0;
    localparam logic [HBYTES_W-1:0] RST_HEAP_BYTES  = 16'd32768;
    localparam logic [MAXREQ_W-1:0] RST_MAX_REQUEST = 31'd1073741824;

    // Header write data select
    typedef enum logic [2:0] {
        WR_INIT  = 3'd0,   // whole heap as one free block
        WR_WHOLE = 3'd1,   // mark fitting block used
        WR_HEAD  = 3'd2,   // front part of a split, used
        WR_TAIL  = 3'd3,   // free remainder of a split
        WR_FREE  = 3'd4    // clear flag bits
    } wr_sel_t;

    typedef struct packed {
        logic                idle;
        logic                walk_start;
        logic                walk_step;
        logic                rd_walk;
        logic                rd_free;
        logic                wr_en;
        wr_sel_t             wr_sel;
        logic                bc_init;
        logic                bc_inc;
        logic                res_set;
        logic                res_addr_en;
        logic [STATUS_W-1:0] res_status;
        logic                out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic              in_valid;
        logic [MODE_W-1:0] mode;
        logic              base_zero;
        logic              req_bad;
        logic              free_bad;
        logic              walk_done;
        logic              pos_out;
        logic              fit;
        logic              whole;
        logic              tail_ok;
        logic              out_busy;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ilff_if.sv =====
`default_nettype none

interface ilff_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [ilff_pkg::MODE_W-1:0] mode;
    logic [ilff_pkg::REQ_W-1:0]  request_size;
    logic [ilff_pkg::ADDR_W-1:0] block_address;

    modport source (output valid, mode, request_size, block_address, input ready);
    modport sink (input valid, mode, request_size, block_address, output ready);
endinterface

interface ilff_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ilff_pkg::ADDR_W-1:0]   payload_address;
    logic [ilff_pkg::STATUS_W-1:0] status;

    modport source (output valid, payload_address, status, input ready);
    modport sink (input valid, payload_address, status, output ready);
endinterface

interface ilff_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ilff_pkg::CFG_IDX_W-1:0]  index;
    logic [ilff_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hdl/implicit_list_first_fit_allocator.sv =====
// Heap allocator engine over an implicit block list, first fit. Each block of
// the heap is led by an 8-byte header (payload size with the used flag in bit
// 0) kept in an on-chip header store of 4096 words. A cmd word carries a mode:
// init lays one free block over the heap (fails if heap_base is zero), allocate
// rounds the request up to 8 bytes and walks the headers in order, taking the
// first free block that fits, whole or split, and returns its payload address;
// free clears the flag bits of the block before an in-heap, word-aligned
// address (status 2 if the address is null, misaligned or outside the heap)
// and never coalesces. Every cmd word yields exactly one rsp word. One word is
// in work at a time. Free reads the header and then writes it back; allocate
// reads each visited header and then runs the fit test on it, since the
// single header-store read port has its read data registered, and a split
// writes the free tail header in a step of its own. A finished rsp word waits
// in an output register, so the next cmd word is accepted while it is unread.
// Configuration words are taken every cycle and must only be sent while the
// engine is idle. The header store is not cleared at reset; headers are only
// meaningful after init.
`default_nettype none

module implicit_list_first_fit_allocator (
    input  wire        logic clk,
    input  wire        logic rst_n,
    ilff_cmd_if.sink   cmd,
    ilff_rsp_if.source rsp,
    ilff_cfg_if.sink   cfg
);

    ilff_pkg::ctl_cmd_t ctl;   // controller -> datapath commands
    ilff_pkg::dp_stat_t st;    // datapath -> controller status

    // Sequencer: decode, header walk, split and free steps
    ilff_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctl   (ctl)
    );

    // Registers, header store, address math and output stage
    ilff_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .rsp   (rsp),
        .cfg   (cfg),
        .ctl   (ctl),
        .st    (st)
    );

endmodule

`default_nettype wire

// ===== hdl/ilff_ctrl.sv =====
`default_nettype none

module ilff_ctrl (
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  ilff_pkg::dp_stat_t st,
    output ilff_pkg::ctl_cmd_t ctl
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DECODE  = 7'b0000010,
        S_WALK    = 7'b0000100,
        S_EVAL    = 7'b0001000,
        S_SPLIT   = 7'b0010000,
        S_FREE_WR = 7'b0100000,
        S_FINISH  = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        ctl        = '0;
        ctl.wr_sel = ilff_pkg::WR_INIT;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.idle = 1'b1;
                if (st.in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (st.mode)
                    ilff_pkg::MODE_INIT:
                    begin
                        ctl.res_set = 1'b1;
                        if (st.base_zero)
                        begin
                            ctl.res_status = ilff_pkg::ST_FAIL;
                        end
                        else
                        begin
                            ctl.wr_en      = 1'b1;
                            ctl.wr_sel     = ilff_pkg::WR_INIT;
                            ctl.bc_init    = 1'b1;
                            ctl.res_status = ilff_pkg::ST_DONE;
                        end
                        state_next = S_FINISH;
                    end
                    ilff_pkg::MODE_ALLOC:
                    begin
                        if (st.req_bad)
                        begin
                            ctl.res_set    = 1'b1;
                            ctl.res_status = ilff_pkg::ST_FAIL;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            ctl.walk_start = 1'b1;
                            state_next     = S_WALK;
                        end
                    end
                    ilff_pkg::MODE_FREE:
                    begin
                        if (st.free_bad)
                        begin
                            ctl.res_set    = 1'b1;
                            ctl.res_status = ilff_pkg::ST_IGNORED;
                            state_next     = S_FINISH;
                        end
                        else
                        begin
                            ctl.rd_free = 1'b1;
                            state_next  = S_FREE_WR;
                        end
                    end
                    default:
                    begin
                        ctl.res_set    = 1'b1;
                        ctl.res_status = ilff_pkg::ST_FAIL;
                        state_next     = S_FINISH;
                    end
                endcase
            end
            S_WALK:
            begin
                if (st.walk_done || st.pos_out)
                begin
                    ctl.res_set    = 1'b1;
                    ctl.res_status = ilff_pkg::ST_FAIL;
                    state_next     = S_FINISH;
                end
                else
                begin
                    ctl.rd_walk = 1'b1;
                    state_next  = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (st.fit)
                begin
                    ctl.wr_en       = 1'b1;
                    ctl.res_set     = 1'b1;
                    ctl.res_addr_en = 1'b1;
                    ctl.res_status  = ilff_pkg::ST_DONE;
                    if (st.whole)
                    begin
                        ctl.wr_sel = ilff_pkg::WR_WHOLE;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        ctl.wr_sel = ilff_pkg::WR_HEAD;
                        state_next = S_SPLIT;
                    end
                end
                else
                begin
                    ctl.walk_step = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_SPLIT:
            begin
                ctl.wr_en  = st.tail_ok;
                ctl.wr_sel = ilff_pkg::WR_TAIL;
                ctl.bc_inc = 1'b1;
                state_next = S_FINISH;
            end
            S_FREE_WR:
            begin
                ctl.wr_en      = 1'b1;
                ctl.wr_sel     = ilff_pkg::WR_FREE;
                ctl.res_set    = 1'b1;
                ctl.res_status = ilff_pkg::ST_DONE;
                state_next     = S_FINISH;
            end
            S_FINISH:
            begin
                if (!st.out_busy)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/ilff_dpath.sv =====
`default_nettype none

module ilff_dpath (
    input  wire                logic clk,
    input  wire                logic rst_n,
    ilff_cmd_if.sink           cmd,
    ilff_rsp_if.source         rsp,
    ilff_cfg_if.sink           cfg,
    input  ilff_pkg::ctl_cmd_t ctl,
    output ilff_pkg::dp_stat_t st
);

    localparam int AW  = ilff_pkg::ADDR_W;
    localparam int HW  = ilff_pkg::HDR_W;
    localparam int HS  = ilff_pkg::HDR_SHIFT;
    localparam int PW  = ilff_pkg::POS_W;
    localparam int MAW = ilff_pkg::HW_AW;
    localparam int RW  = ilff_pkg::REQ_W;

    // Configuration
    logic [AW-1:0]                 base_reg;
    logic [ilff_pkg::HBYTES_W-1:0] hbytes_reg;
    logic [ilff_pkg::MAXREQ_W-1:0] maxreq_reg;

    // Latched input word
    logic [ilff_pkg::MODE_W-1:0] mode_reg;
    logic [RW-1:0]               req_reg;
    logic [AW-1:0]               baddr_reg;

    // Walk state
    logic [RW-1:0]             need_reg;
    logic [PW-1:0]             pos_reg;
    logic [ilff_pkg::BC_W-1:0] cnt_reg;
    logic [ilff_pkg::BC_W-1:0] bc_reg;

    // Header store
    logic [HW-1:0] mem [ilff_pkg::HEAP_WORDS];
    logic [HW-1:0] rd_data_reg;

    // Result and output stage
    logic [AW-1:0]                 res_addr_reg;
    logic [ilff_pkg::STATUS_W-1:0] res_status_reg;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [AW-1:0]                 out_addr_reg;
    logic [ilff_pkg::STATUS_W-1:0] out_status_reg;

    logic          in_fire;
    logic          cfg_fire;
    logic [HW-1:0] size_eff;
    logic [HW-1:0] size_floor;
    logic [RW:0]   need_sum;
    logic [AW:0]   off_full;
    logic [AW-1:0] off;
    logic [MAW-1:0] free_idx;
    logic [HW-1:0] hsize;
    logic [PW-1:0] next_pos;
    logic [PW-1:0] step_pos;
    logic [AW-1:0] hit_addr;
    logic [MAW-1:0] waddr;
    logic [HW-1:0]  wdata;
    logic [MAW-1:0] raddr;

    assign in_fire   = cmd.valid && ctl.idle;
    assign cmd.ready = ctl.idle;
    assign cfg_fire  = cfg.valid;
    assign cfg.ready = 1'b1;

    // Heap size rounded down to a word and clamped
    always_comb
    begin
        size_floor = {hbytes_reg[HW-1:HS], {HS{1'b0}}};
        priority if (32'(size_floor) < ilff_pkg::HEAP_MIN_BYTES)
        begin
            size_eff = HW'(ilff_pkg::HEAP_MIN_BYTES);
        end
        else if (32'(size_floor) > ilff_pkg::HEAP_MAX_BYTES)
        begin
            size_eff = HW'(ilff_pkg::HEAP_MAX_BYTES);
        end
        else
        begin
            size_eff = size_floor;
        end
    end

    // Request rounded up to alignment; only used when below max_request
    assign need_sum = ((RW+1)'(req_reg) + (RW+1)'(ilff_pkg::ALIGN_BYTES - 1))
                      & ~(RW+1)'(ilff_pkg::ALIGN_BYTES - 1);

    // Free address offset into the heap
    assign off_full = {1'b0, baddr_reg} - {1'b0, base_reg};
    assign off      = off_full[AW-1:0];
    assign free_idx = off[MAW+HS-1:HS] - MAW'(1);

    assign hsize    = {rd_data_reg[HW-1:HS], {HS{1'b0}}};
    assign next_pos = pos_reg + PW'(need_reg[HW-1:HS]) + PW'(1);
    assign step_pos = pos_reg + PW'(rd_data_reg[HW-1:HS]) + PW'(1);
    assign hit_addr = base_reg + AW'({pos_reg[MAW-1:0], {HS{1'b0}}})
                      + AW'(ilff_pkg::HEADER_BYTES);

    // Status toward the controller
    always_comb
    begin
        st.in_valid  = cmd.valid;
        st.mode      = mode_reg;
        st.base_zero = (base_reg == '0);
        st.req_bad   = (req_reg == '0) || (req_reg >= RW'(maxreq_reg));
        st.free_bad  = (baddr_reg == '0) || off_full[AW]
                       || (off < AW'(ilff_pkg::HEADER_BYTES))
                       || (off >= AW'(size_eff))
                       || (off[HS-1:0] != '0);
        st.walk_done = (cnt_reg >= bc_reg);
        st.pos_out   = (32'(pos_reg) >= ilff_pkg::HEAP_WORDS);
        st.fit       = (rd_data_reg[HS-1:0] == '0) && (RW'(hsize) >= need_reg);
        st.whole     = ((RW+1)'(need_reg) + (RW+1)'(ilff_pkg::HEADER_BYTES))
                       >= (RW+1)'(hsize);
        st.tail_ok   = (32'(next_pos) < ilff_pkg::HEAP_WORDS);
        st.out_busy  = out_valid_reg && !rsp.ready;
    end

    // Header write port
    always_comb
    begin
        unique case (ctl.wr_sel)
            ilff_pkg::WR_INIT:
            begin
                waddr = '0;
                wdata = size_eff - HW'(ilff_pkg::HEADER_BYTES);
            end
            ilff_pkg::WR_WHOLE:
            begin
                waddr = pos_reg[MAW-1:0];
                wdata = rd_data_reg | HW'(1);
            end
            ilff_pkg::WR_HEAD:
            begin
                waddr = pos_reg[MAW-1:0];
                wdata = need_reg[HW-1:0] | HW'(1);
            end
            ilff_pkg::WR_TAIL:
            begin
                waddr = next_pos[MAW-1:0];
                wdata = hsize - HW'(ilff_pkg::HEADER_BYTES) - need_reg[HW-1:0];
            end
            ilff_pkg::WR_FREE:
            begin
                waddr = free_idx;
                wdata = rd_data_reg & ~HW'((1 << HS) - 1);
            end
            default:
            begin
                waddr = '0;
                wdata = '0;
            end
        endcase
    end

    assign raddr = ctl.rd_free ? free_idx : pos_reg[MAW-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (ctl.rd_walk || ctl.rd_free)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= ilff_pkg::RST_HEAP_BASE;
            hbytes_reg    <= ilff_pkg::RST_HEAP_BYTES;
            maxreq_reg    <= ilff_pkg::RST_MAX_REQUEST;
            bc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_fire)
            begin
                unique case (cfg.index)
                    ilff_pkg::REG_HEAP_BASE:   base_reg   <= cfg.data[AW-1:0];
                    ilff_pkg::REG_HEAP_BYTES:  hbytes_reg <= cfg.data[ilff_pkg::HBYTES_W-1:0];
                    ilff_pkg::REG_MAX_REQUEST: maxreq_reg <= cfg.data[ilff_pkg::MAXREQ_W-1:0];
                    default:                   ;
                endcase
            end
            if (ctl.bc_init)
            begin
                bc_reg <= ilff_pkg::BC_W'(1);
            end
            else if (ctl.bc_inc)
            begin
                bc_reg <= bc_reg + ilff_pkg::BC_W'(1);
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        priority if (ctl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= cmd.mode;
            req_reg   <= cmd.request_size;
            baddr_reg <= cmd.block_address;
        end
        if (ctl.walk_start)
        begin
            need_reg <= need_sum[RW-1:0];
            pos_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (ctl.walk_step)
        begin
            pos_reg <= step_pos;
            cnt_reg <= cnt_reg + ilff_pkg::BC_W'(1);
        end
        if (ctl.res_set)
        begin
            res_status_reg <= ctl.res_status;
            res_addr_reg   <= ctl.res_addr_en ? hit_addr : '0;
        end
        if (ctl.out_load)
        begin
            out_addr_reg   <= res_addr_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.payload_address = out_addr_reg;
    assign rsp.status          = out_status_reg;

endmodule

`default_nettype wire
